>>> rtl/ssb_pkg.sv
// ----------------------------------------------------------------------------
// ssb_pkg
// Shared constants and types for the scaled sprite blit.
// ----------------------------------------------------------------------------
package ssb_pkg;

   localparam int SCREEN_W       = 1024;
   localparam int SCREEN_H       = 768;
   localparam int SPRITE_ENTRIES = 4096;
   localparam int SIDX_W         = $clog2(SPRITE_ENTRIES);

   localparam int Q_W   = 7;
   localparam int NUM_W = 18;
   localparam int POS_W = 13;

   localparam logic [2:0] REG_DEST_X     = 3'd0;
   localparam logic [2:0] REG_DEST_Y     = 3'd1;
   localparam logic [2:0] REG_OUT_WIDTH  = 3'd2;
   localparam logic [2:0] REG_OUT_HEIGHT = 3'd3;
   localparam logic [2:0] REG_SRC_WIDTH  = 3'd4;
   localparam logic [2:0] REG_SRC_HEIGHT = 3'd5;
   localparam logic [2:0] REG_KEY_COLOR  = 3'd6;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_DRAW = 1'b1;

   typedef struct packed {
      logic        draw;
      logic        in_rect;
      logic [9:0]  row;
      logic [9:0]  col;
      logic [11:0] texel_index;
      logic [7:0]  texel_value;
   } side_type;

endpackage

>>> rtl/scaled_sprite_blit.sv
// ----------------------------------------------------------------------------
// scaled_sprite_blit
// Nearest-neighbor scaled sprite blit with color key, one beat per cycle unless rsp stalls.
// ----------------------------------------------------------------------------
//  channel  direction  handshake           payload
//  req      in         req_valid/req_stall cmd, texel_index, texel_value,
//                                          out_row, out_col
//  rsp      out        rsp_valid/rsp_stall write_enable, dest_addr, color
//  csr      in         APB write/read      seven registers at 4*i
//
//  One beat per cycle while rsp is not stalled; only draws produce a result
//  beat. A draw passes through the product stage, the 7-stage restoring divider
//  pipeline, the address stage, the registered sprite store read and the result
//  register. Loads and draws share the store port in order.
//  Reset clears all valids and the CSR registers; data registers and the store are not cleared.
//  A stall on rsp while rsp_valid is high freezes the whole pipeline and raises req_stall.
// ----------------------------------------------------------------------------
module scaled_sprite_blit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_cmd,
   input  logic [11:0] req_texel_index,
   input  logic [7:0]  req_texel_value,
   input  logic [9:0]  req_out_row,
   input  logic [9:0]  req_out_col,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_write_enable,
   output logic [19:0] rsp_dest_addr,
   output logic [7:0]  rsp_color,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import ssb_pkg::*;

   logic signed [10:0] dest_x_ff, dest_y_ff;
   logic [10:0] out_w_ff, out_h_ff;
   logic [6:0]  src_w_ff, src_h_ff;
   logic [7:0]  key_ff;
   logic [2:0]  reg_sel;
   logic        en;

   assign pready  = 1'b1;
   assign reg_sel = paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         dest_x_ff <= '0;
         dest_y_ff <= '0;
         out_w_ff  <= 11'd1;
         out_h_ff  <= 11'd1;
         src_w_ff  <= 7'd1;
         src_h_ff  <= 7'd1;
         key_ff    <= '0;
      end else if (psel && penable && pwrite) begin
         case (reg_sel)
            REG_DEST_X:     dest_x_ff <= pwdata[10:0];
            REG_DEST_Y:     dest_y_ff <= pwdata[10:0];
            REG_OUT_WIDTH:  out_w_ff  <= pwdata[10:0];
            REG_OUT_HEIGHT: out_h_ff  <= pwdata[10:0];
            REG_SRC_WIDTH:  src_w_ff  <= pwdata[6:0];
            REG_SRC_HEIGHT: src_h_ff  <= pwdata[6:0];
            REG_KEY_COLOR:  key_ff    <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_DEST_X:     prdata = {{21{dest_x_ff[10]}}, dest_x_ff};
         REG_DEST_Y:     prdata = {{21{dest_y_ff[10]}}, dest_y_ff};
         REG_OUT_WIDTH:  prdata = {21'd0, out_w_ff};
         REG_OUT_HEIGHT: prdata = {21'd0, out_h_ff};
         REG_SRC_WIDTH:  prdata = {25'd0, src_w_ff};
         REG_SRC_HEIGHT: prdata = {25'd0, src_h_ff};
         REG_KEY_COLOR:  prdata = {24'd0, key_ff};
         default:        prdata = '0;
      endcase
   end

   logic            rsp_valid_ff;
   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   // entry stage: products
   logic           s0_valid_ff;
   side_type       s0_side_ff;
   logic [NUM_W-1:0] s0_ny_ff, s0_nx_ff;

   always_ff @(posedge clock) begin
      if (reset) s0_valid_ff <= 1'b0;
      else if (en) s0_valid_ff <= req_valid;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_side_ff.draw        <= (req_cmd == CMD_DRAW);
         s0_side_ff.in_rect     <= ({1'b0, req_out_row} < out_h_ff) &&
                                   ({1'b0, req_out_col} < out_w_ff);
         s0_side_ff.row         <= req_out_row;
         s0_side_ff.col         <= req_out_col;
         s0_side_ff.texel_index <= req_texel_index;
         s0_side_ff.texel_value <= req_texel_value;
         s0_ny_ff <= NUM_W'(req_out_row * src_h_ff);
         s0_nx_ff <= NUM_W'(req_out_col * src_w_ff);
      end
   end

   // divider stages, one quotient bit each
   logic             dv_valid_ff [Q_W];
   side_type         dv_side_ff  [Q_W];
   logic [NUM_W-1:0] dv_ry_ff [Q_W], dv_rx_ff [Q_W];
   logic [Q_W-1:0]   dv_qy_ff [Q_W], dv_qx_ff [Q_W];
   logic [NUM_W-1:0] dv_ry_in [Q_W], dv_rx_in [Q_W];
   logic [Q_W-1:0]   dv_qy_in [Q_W], dv_qx_in [Q_W];

   always_comb begin
      logic [NUM_W-1:0] ry, rx, dy, dx;
      logic [Q_W-1:0]   qy, qx;
      for (int i = 0; i < Q_W; i++) begin
         ry = (i == 0) ? s0_ny_ff : dv_ry_ff[(i == 0) ? 0 : i - 1];
         rx = (i == 0) ? s0_nx_ff : dv_rx_ff[(i == 0) ? 0 : i - 1];
         qy = (i == 0) ? '0 : dv_qy_ff[(i == 0) ? 0 : i - 1];
         qx = (i == 0) ? '0 : dv_qx_ff[(i == 0) ? 0 : i - 1];
         dy = NUM_W'(out_h_ff) << (Q_W - 1 - i);
         dx = NUM_W'(out_w_ff) << (Q_W - 1 - i);
         if (ry >= dy) begin
            ry = ry - dy;
            qy[Q_W-1-i] = 1'b1;
         end
         if (rx >= dx) begin
            rx = rx - dx;
            qx[Q_W-1-i] = 1'b1;
         end
         dv_ry_in[i] = ry;
         dv_rx_in[i] = rx;
         dv_qy_in[i] = qy;
         dv_qx_in[i] = qx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < Q_W; i++) dv_valid_ff[i] <= 1'b0;
      end else if (en) begin
         dv_valid_ff[0] <= s0_valid_ff;
         for (int i = 1; i < Q_W; i++) dv_valid_ff[i] <= dv_valid_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dv_side_ff[0] <= s0_side_ff;
         for (int i = 1; i < Q_W; i++) dv_side_ff[i] <= dv_side_ff[i-1];
         for (int i = 0; i < Q_W; i++) begin
            dv_ry_ff[i] <= dv_ry_in[i];
            dv_rx_ff[i] <= dv_rx_in[i];
            dv_qy_ff[i] <= dv_qy_in[i];
            dv_qx_ff[i] <= dv_qx_in[i];
         end
      end
   end

   // address stage
   logic              ad_valid_ff, ad_ok_ff;
   side_type          ad_side_ff;
   logic [SIDX_W-1:0] ad_sidx_ff;
   logic [19:0]       ad_addr_ff;
   logic signed [POS_W-1:0] px, py;
   logic              on_screen;

   assign px = POS_W'(dest_x_ff) + POS_W'({1'b0, dv_side_ff[Q_W-1].col});
   assign py = POS_W'(dest_y_ff) + POS_W'({1'b0, dv_side_ff[Q_W-1].row});
   assign on_screen = (px >= 0) && (px < POS_W'(SCREEN_W)) &&
                      (py >= 0) && (py < POS_W'(SCREEN_H));

   always_ff @(posedge clock) begin
      if (reset) ad_valid_ff <= 1'b0;
      else if (en) ad_valid_ff <= dv_valid_ff[Q_W-1];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ad_side_ff <= dv_side_ff[Q_W-1];
         ad_ok_ff   <= dv_side_ff[Q_W-1].in_rect && on_screen;
         ad_sidx_ff <= SIDX_W'(dv_qy_ff[Q_W-1] * src_w_ff + 14'(dv_qx_ff[Q_W-1]));
         ad_addr_ff <= 20'(32'(unsigned'(py)) * 32'(SCREEN_W) + 32'(unsigned'(px)));
      end
   end

   // sprite store access
   logic [7:0]  store_mem [SPRITE_ENTRIES];
   logic [7:0]  rd_data_ff;
   logic        mm_valid_ff, mm_draw_ff, mm_ok_ff;
   logic [19:0] mm_addr_ff;

   always_ff @(posedge clock) begin
      if (en && ad_valid_ff) begin
         if (!ad_side_ff.draw) begin
            if (32'(ad_side_ff.texel_index) < 32'(SPRITE_ENTRIES))
               store_mem[SIDX_W'(ad_side_ff.texel_index)] <= ad_side_ff.texel_value;
         end else begin
            rd_data_ff <= store_mem[ad_sidx_ff];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) mm_valid_ff <= 1'b0;
      else if (en) mm_valid_ff <= ad_valid_ff && ad_side_ff.draw;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mm_draw_ff <= ad_side_ff.draw;
         mm_ok_ff   <= ad_ok_ff;
         mm_addr_ff <= ad_addr_ff;
      end
   end

   // result register
   logic        we;
   logic        we_ff;
   logic [19:0] addr_ff;
   logic [7:0]  color_ff;

   assign we = mm_draw_ff && mm_ok_ff && (rd_data_ff != key_ff);

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (en) rsp_valid_ff <= mm_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         we_ff    <= we;
         addr_ff  <= we ? mm_addr_ff : '0;
         color_ff <= we ? rd_data_ff : '0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_write_enable = we_ff;
   assign rsp_dest_addr    = addr_ff;
   assign rsp_color        = color_ff;

endmodule

>>> bench/scaled_sprite_blit_tb.sv
// ----------------------------------------------------------------------------
// scaled_sprite_blit_tb
// Self-checking bench for the scaled sprite blit. Loads sprites, draws pixels
// across several register settings and compares every result beat with a
// nearest-neighbor predictor under random valid gaps and result stalls.
// ----------------------------------------------------------------------------
module scaled_sprite_blit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ssb_pkg::*;

   typedef struct {
      logic        cmd;
      logic [11:0] texel_index;
      logic [7:0]  texel_value;
      logic [9:0]  out_row;
      logic [9:0]  out_col;
   } req_item_type;

   typedef struct {
      logic        write_enable;
      logic [19:0] dest_addr;
      logic [7:0]  color;
   } pixel_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_cmd = CMD_LOAD;
   logic [11:0] req_texel_index = '0;
   logic [7:0]  req_texel_value = '0;
   logic [9:0]  req_out_row = '0;
   logic [9:0]  req_out_col = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_write_enable;
   logic [19:0] rsp_dest_addr;
   logic [7:0]  rsp_color;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [4:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   scaled_sprite_blit dut (.*);

   always #5 clock = ~clock;

   // predictor state
   int          ref_dest_x, ref_dest_y;
   int unsigned ref_out_w, ref_out_h, ref_src_w, ref_src_h, ref_key;
   logic [7:0]  ref_texels [SPRITE_ENTRIES];

   req_item_type pending_reqs[$];
   pixel_type    expected_pixels[$];
   int        mismatches = 0;
   int        cycle_count = 0;
   bit        calm = 1'b0;
   bit        done = 1'b0;
   bit        req_taken = 1'b0;

   function automatic void predict_pixel(req_item_type it);
      pixel_type   p;
      int unsigned sy, sx, sidx;
      int          px, py;
      logic [7:0]  c;
      p = '{1'b0, 20'd0, 8'd0};
      if (it.cmd == CMD_LOAD) begin
         ref_texels[it.texel_index] = it.texel_value;
         return;
      end
      if (it.out_row < ref_out_h && it.out_col < ref_out_w) begin
         sy = it.out_row * ref_src_h / ref_out_h;
         sx = it.out_col * ref_src_w / ref_out_w;
         sidx = (sy * ref_src_w + sx) % SPRITE_ENTRIES;
         c = ref_texels[sidx];
         px = ref_dest_x + int'(it.out_col);
         py = ref_dest_y + int'(it.out_row);
         if (c != ref_key && px >= 0 && px < SCREEN_W && py >= 0 && py < SCREEN_H) begin
            p.write_enable = 1'b1;
            p.dest_addr = 20'(py * SCREEN_W + px);
            p.color = c;
         end
      end
      expected_pixels.push_back(p);
   endfunction

   always @(posedge clock) begin
      req_taken <= req_valid && !req_stall;
   end

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_taken) begin
            if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= 12)) begin
               req_item_type it;
               it = pending_reqs.pop_front();
               predict_pixel(it);
               req_valid <= 1'b1;
               req_cmd <= it.cmd;
               req_texel_index <= it.texel_index;
               req_texel_value <= it.texel_value;
               req_out_row <= it.out_row;
               req_out_col <= it.out_col;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= calm ? 1'b0 : ($urandom_range(99) < 12);
      end
   end

   // monitor
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected beat: we=%0d addr=%0d color=%0d",
                        rsp_write_enable, rsp_dest_addr, rsp_color);
         end else begin
            pixel_type e;
            e = expected_pixels.pop_front();
            if (rsp_write_enable !== e.write_enable || rsp_dest_addr !== e.dest_addr ||
                rsp_color !== e.color) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp we=%0d addr=%0d color=%0d %s",
                           e.write_enable, e.dest_addr, e.color,
                           $sformatf("got we=%0d addr=%0d color=%0d",
                                     rsp_write_enable, rsp_dest_addr, rsp_color));
            end
         end
      end
      if (cycle_count > 400000 && !done) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic csr_write(logic [2:0] idx, logic [31:0] value);
      @(negedge clock);
      psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
      paddr <= {idx, 2'b00}; pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      case (idx)
         REG_DEST_X:     ref_dest_x = $signed(value[10:0]);
         REG_DEST_Y:     ref_dest_y = $signed(value[10:0]);
         REG_OUT_WIDTH:  ref_out_w = value[10:0];
         REG_OUT_HEIGHT: ref_out_h = value[10:0];
         REG_SRC_WIDTH:  ref_src_w = value[6:0];
         REG_SRC_HEIGHT: ref_src_h = value[6:0];
         REG_KEY_COLOR:  ref_key = value[7:0];
         default: ;
      endcase
   endtask

   task automatic drain();
      while (pending_reqs.size() > 0 || expected_pixels.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic setup_blit(int dx, int dy, int ow, int oh, int sw, int sh, int key);
      csr_write(REG_DEST_X, 32'(dx));
      csr_write(REG_DEST_Y, 32'(dy));
      csr_write(REG_OUT_WIDTH, 32'(ow));
      csr_write(REG_OUT_HEIGHT, 32'(oh));
      csr_write(REG_SRC_WIDTH, 32'(sw));
      csr_write(REG_SRC_HEIGHT, 32'(sh));
      csr_write(REG_KEY_COLOR, 32'(key));
   endtask

   function automatic void push_load(int idx, int val);
      pending_reqs.push_back('{CMD_LOAD, 12'(idx), 8'(val), 10'($urandom), 10'($urandom)});
   endfunction

   function automatic void push_draw(int row, int col);
      pending_reqs.push_back('{CMD_DRAW, 12'($urandom), 8'($urandom), 10'(row), 10'(col)});
   endfunction

   function automatic void load_sprite(int sw, int sh, int key);
      for (int i = 0; i < sw * sh; i++)
         push_load(i, ($urandom_range(3) == 0) ? key : $urandom_range(255));
   endfunction

   initial begin
      int sw, sh, ow, oh, n;
      ref_dest_x = 0; ref_dest_y = 0; ref_out_w = 1; ref_out_h = 1;
      ref_src_w = 1; ref_src_h = 1; ref_key = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: write the corner entries that the corner draws reach
      setup_blit(-1024, 1023, 1024, 1024, 64, 64, 0);
      push_load(0, 0);
      push_load(63, 255);
      push_load(4032, 8'h5C);
      push_load(4095, 8'hAA);
      push_draw(0, 0);
      push_draw(1023, 1023);
      push_draw(1023, 0);
      push_draw(0, 1023);
      calm = 1'b1;
      drain();
      calm = 1'b0;
      setup_blit(0, 0, 1024, 768, 64, 64, 255);
      push_draw(0, 0);
      push_draw(767, 1023);
      push_draw(768, 5);
      push_draw(5, 1023);
      push_draw(1023, 1023);
      push_draw(0, 1023);
      drain();
      setup_blit(1023, -1024, 1, 1, 1, 1, 0);
      push_draw(0, 0);
      push_draw(1, 0);
      push_draw(0, 1);
      drain();

      // random phases
      for (int ph = 0; ph < 12; ph++) begin
         sw = (ph == 0) ? 64 : $urandom_range(1, 8);
         sh = (ph == 1) ? 64 : $urandom_range(1, 8);
         ow = (ph == 3) ? 1024 : $urandom_range(1, 96);
         oh = (ph == 5) ? 1024 : $urandom_range(1, 96);
         setup_blit($urandom_range(0, 1200) - 100, $urandom_range(0, 900) - 100,
                    ow, oh, sw, sh, $urandom_range(255));
         load_sprite(sw, sh, ref_key);
         calm = (ph == 6);
         n = 80;
         for (int k = 0; k < n; k++) begin
            if ($urandom_range(9) == 0)
               push_draw($urandom_range(1023), $urandom_range(1023));
            else if ($urandom_range(19) == 0)
               push_load(sw * sh + $urandom_range(4095 - sw * sh), $urandom_range(255));
            else
               push_draw($urandom_range(oh - 1), $urandom_range(ow - 1));
         end
         drain();
         calm = 1'b0;
      end

      done = 1'b1;
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
